// ----- hdl/pdre_pkg.sv -----
// ----------------------------------------------------------------------------
// pdre_pkg
// shared types, register indexes, reset values and the rate threshold table
// ----------------------------------------------------------------------------
`default_nettype none

package pdre_pkg;

    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_PACKET_SIZE    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_WIDTH    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SENTINEL_DELAY = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_WINDOW     = 8'd3;

    localparam logic [15:0] PACKET_SIZE_RST = 16'd1500;
    localparam logic [15:0] RANGE_WIDTH_RST = 16'd50;
    localparam logic [31:0] SENTINEL_RST    = 32'hFFFF_FFFF;
    localparam logic [4:0]  MIN_WINDOW_RST  = 5'd4;

    localparam int          DEN_W     = 16;
    localparam int          GROW_STEP = 2;
    localparam logic [15:0] EST_MAX   = 16'hFFFF;
    localparam logic [2:0]  RATE_TOP  = 3'd7;

    localparam logic [7:0] RATE_BOUND [7] = '{8'd38, 8'd53, 8'd78, 8'd105,
                                              8'd150, 8'd210, 8'd255};

    typedef enum logic [2:0] {
        EV_STORED = 3'd0,
        EV_GROWN  = 3'd1,
        EV_RETRY  = 3'd2,
        EV_RESET  = 3'd3,
        EV_RATE   = 3'd4
    } event_t;

    typedef struct packed {
        logic wr_en;
        logic clear;
    } st_ctl_t;

    function automatic logic [2:0] rate_of_quotient(input logic [15:0] q);
        logic [2:0] code;
        int k;
        code = RATE_TOP;
        for (k = 6; k >= 0; k--) begin
            if (q < {8'd0, RATE_BOUND[k]}) begin
                code = 3'(k);
            end
        end
        return code;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/pdre_store.sv -----
// ----------------------------------------------------------------------------
// pdre_store
// sorted delay store: one write port, one registered read port, per-entry
// valid bits, so a clear resets all at once and empty entries read as the fill
// ----------------------------------------------------------------------------
`default_nettype none

module pdre_store #(
    parameter int   DEPTH = 16,
    parameter int   DW    = 32,
    localparam int  AW    = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire pdre_pkg::st_ctl_t ctl,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire logic [DW-1:0]     wr_data,
    input  wire logic [DW-1:0]     clear_value,
    input  wire logic [AW-1:0]     rd_addr,
    output logic [DW-1:0]          rd_data
);
    import pdre_pkg::*;

    logic [DW-1:0]    mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [DW-1:0]    fill_reg;
    logic [DW-1:0]    rd_data_reg;
    logic             rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            fill_reg     <= SENTINEL_RST[DW-1:0];
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= valid_reg[rd_addr];
            if (ctl.clear) begin
                valid_reg <= '0;
                fill_reg  <= clear_value;
            end else if (ctl.wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : fill_reg;

endmodule

`default_nettype wire

// ----- hdl/pdre_div.sv -----
// ----------------------------------------------------------------------------
// pdre_div
// radix-2 restoring divider, one quotient bit per cycle, shared by the run
// average and the rate estimate
// ----------------------------------------------------------------------------
`default_nettype none

module pdre_div #(
    parameter int NUM_W = 37
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [NUM_W-1:0]             num,
    input  wire logic [pdre_pkg::DEN_W-1:0]   den,
    output logic                              done,
    output logic [NUM_W-1:0]                  quo
);
    import pdre_pkg::*;

    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   trial;

    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign trial   = shifted - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            if (!trial[DEN_W]) begin
                rem_reg <= trial[DEN_W-1:0];
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_reg <= shifted[DEN_W-1:0];
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

// ----- hdl/pdre_seq.sv -----
// ----------------------------------------------------------------------------
// pdre_seq
// sequencer: sorted insert, two-pointer run search, run sum, average and
// rate estimate through the shared divider, result register
// ----------------------------------------------------------------------------
`default_nettype none

module pdre_seq #(
    parameter int  MAX_WINDOW = 16,
    parameter int  DW         = 32,
    localparam int AW         = $clog2(MAX_WINDOW),
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1),
    localparam int SUM_W      = DW + CNT_W
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [DW-1:0]              s_delay,
    input  wire logic [15:0]                packet_size,
    input  wire logic [15:0]                range_width,
    input  wire logic [DW-1:0]              sentinel,
    input  wire logic [4:0]                 min_window,
    output pdre_pkg::st_ctl_t               st_ctl,
    output logic [AW-1:0]                   st_wr_addr,
    output logic [DW-1:0]                   st_wr_data,
    output logic [AW-1:0]                   st_rd_addr,
    input  wire logic [DW-1:0]              st_rd_data,
    output logic                            div_start,
    output logic [SUM_W-1:0]                div_num,
    output logic [pdre_pkg::DEN_W-1:0]      div_den,
    input  wire logic                       div_done,
    input  wire logic [SUM_W-1:0]           div_quo,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output pdre_pkg::event_t                m_event,
    output logic                            m_send,
    output logic [2:0]                      m_rate,
    output logic                            m_known,
    output logic [DW-1:0]                   m_avg
);
    import pdre_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_INS_TOP, S_INS_SHIFT, S_INS_PUT, S_DECIDE, S_BASE_REQ, S_BASE,
        S_EXT, S_EVAL, S_JUDGE, S_SUM, S_AVG_GO, S_AVG_WAIT, S_AVG_CHK,
        S_RATE_WAIT, S_OUT
    } state_t;

    function automatic logic [CNT_W-1:0] lim(input int v);
        return (v > MAX_WINDOW) ? CNT_W'(MAX_WINDOW) : CNT_W'(v);
    endfunction

    localparam logic [CNT_W-1:0] WIN_RST = lim(int'(MIN_WINDOW_RST) + 1);
    localparam logic [CNT_W-1:0] WIN_MAX = CNT_W'(MAX_WINDOW);

    state_t           state_reg;
    logic [DW-1:0]    d_reg;
    logic [AW-1:0]    j_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] win_reg;
    logic             retry_reg;
    logic [2:0]       rate_reg;
    logic             known_reg;
    logic [CNT_W-1:0] i_reg;
    logic [CNT_W-1:0] e_reg;
    logic [CNT_W-1:0] best_reg;
    logic [CNT_W-1:0] bpos_reg;
    logic [CNT_W-1:0] k_reg;
    logic [DW-1:0]    base_reg;
    logic [SUM_W-1:0] acc_reg;
    logic [DW-1:0]    avg_reg;
    event_t           ev_reg;
    logic             send_reg;
    logic [DW-1:0]    avg_out_reg;
    logic             m_valid_reg;
    event_t           m_event_reg;
    logic             m_send_reg;
    logic [2:0]       m_rate_reg;
    logic             m_known_reg;
    logic [DW-1:0]    m_avg_reg;

    logic [AW-1:0]    last_idx;
    logic [CNT_W-1:0] count_inc;
    logic [CNT_W-1:0] win_min;
    logic [CNT_W-1:0] win_min1;
    logic [CNT_W-1:0] win_grow;
    logic             d_below;
    logic             in_range;
    logic [CNT_W-1:0] run_len;
    logic [CNT_W-1:0] sum_end;
    logic [CNT_W-1:0] e_plus;
    logic [CNT_W-1:0] i_plus;
    logic [CNT_W-1:0] k_plus;
    logic [15:0]      est;
    logic             avg_is_sent;

    assign last_idx  = (count_reg > CNT_W'(MAX_WINDOW - 1)) ? AW'(MAX_WINDOW - 1)
                                                             : count_reg[AW-1:0];
    assign count_inc = (count_reg < WIN_MAX) ? count_reg + CNT_W'(1) : count_reg;
    assign win_min   = lim(int'(min_window));
    assign win_min1  = lim(int'(min_window) + 1);
    assign win_grow  = lim(int'(win_reg) + GROW_STEP);
    assign d_below   = d_reg < st_rd_data;
    assign in_range  = (st_rd_data - base_reg) <= DW'(range_width);
    assign run_len   = e_reg - i_reg - CNT_W'(1);
    assign sum_end   = bpos_reg + best_reg;
    assign e_plus    = e_reg + CNT_W'(1);
    assign i_plus    = i_reg + CNT_W'(1);
    assign k_plus    = k_reg + CNT_W'(1);
    assign est       = (avg_reg > DW'(EST_MAX)) ? EST_MAX : avg_reg[15:0];
    assign avg_is_sent = avg_reg == sentinel;

    // store and divider control
    always_comb begin
        st_ctl     = '0;
        st_wr_addr = j_reg;
        st_wr_data = d_reg;
        st_rd_addr = last_idx;
        div_start  = 1'b0;
        div_num    = acc_reg;
        div_den    = DEN_W'(best_reg) + DEN_W'(1);
        case (state_reg)
            S_INS_TOP: begin
                st_rd_addr   = j_reg - AW'(1);
                st_ctl.wr_en = d_below && (j_reg == '0);
            end
            S_INS_SHIFT: begin
                st_rd_addr   = j_reg - AW'(2);
                st_ctl.wr_en = 1'b1;
                st_wr_data   = d_below ? st_rd_data : d_reg;
            end
            S_INS_PUT: begin
                st_ctl.wr_en = 1'b1;
            end
            S_BASE_REQ: begin
                st_rd_addr = i_reg[AW-1:0];
            end
            S_BASE: begin
                st_rd_addr = e_reg[AW-1:0];
            end
            S_EXT: begin
                st_rd_addr = e_plus[AW-1:0];
            end
            S_JUDGE: begin
                st_rd_addr   = bpos_reg[AW-1:0];
                st_ctl.clear = (best_reg < CNT_W'(2)) && (win_reg == WIN_MAX);
            end
            S_SUM: begin
                st_rd_addr = k_plus[AW-1:0];
            end
            S_AVG_GO: begin
                div_start = 1'b1;
            end
            S_AVG_CHK: begin
                div_num      = SUM_W'(packet_size);
                div_den      = est;
                div_start    = !avg_is_sent && (est != '0);
                st_ctl.clear = avg_is_sent || (est == '0);
            end
            S_RATE_WAIT: begin
                st_ctl.clear = div_done;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            win_reg     <= WIN_RST;
            retry_reg   <= 1'b0;
            rate_reg    <= '0;
            known_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != S_OUT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        d_reg     <= s_delay;
                        j_reg     <= last_idx;
                        count_reg <= count_inc;
                        state_reg <= S_INS_TOP;
                    end
                end
                S_INS_TOP: begin
                    if (!d_below || j_reg == '0) begin
                        state_reg <= S_DECIDE;
                    end else begin
                        state_reg <= S_INS_SHIFT;
                    end
                end
                S_INS_SHIFT: begin
                    if (d_below) begin
                        j_reg <= j_reg - AW'(1);
                        if (j_reg == AW'(1)) begin
                            state_reg <= S_INS_PUT;
                        end
                    end else begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_INS_PUT: begin
                    state_reg <= S_DECIDE;
                end
                S_DECIDE: begin
                    i_reg    <= '0;
                    e_reg    <= CNT_W'(1);
                    best_reg <= '0;
                    bpos_reg <= '0;
                    if (count_reg >= win_reg) begin
                        state_reg <= (win_reg == '0) ? S_JUDGE : S_BASE_REQ;
                    end else begin
                        ev_reg      <= EV_STORED;
                        send_reg    <= 1'b0;
                        avg_out_reg <= '0;
                        state_reg   <= S_OUT;
                    end
                end
                S_BASE_REQ: begin
                    state_reg <= S_BASE;
                end
                S_BASE: begin
                    base_reg  <= st_rd_data;
                    state_reg <= (e_reg < win_reg) ? S_EXT : S_EVAL;
                end
                S_EXT: begin
                    if (in_range) begin
                        e_reg <= e_plus;
                        if (e_plus >= win_reg) begin
                            state_reg <= S_EVAL;
                        end
                    end else begin
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (run_len > best_reg) begin
                        best_reg <= run_len;
                        bpos_reg <= i_reg;
                    end
                    if (i_plus < win_reg) begin
                        i_reg <= i_plus;
                        if (e_reg == i_plus) begin
                            e_reg <= e_plus;
                        end
                        state_reg <= S_BASE_REQ;
                    end else begin
                        state_reg <= S_JUDGE;
                    end
                end
                S_JUDGE: begin
                    if (best_reg < CNT_W'(2)) begin
                        avg_out_reg <= '0;
                        state_reg   <= S_OUT;
                        if (win_reg == WIN_MAX) begin
                            send_reg  <= 1'b1;
                            count_reg <= '0;
                            if (retry_reg) begin
                                win_reg   <= win_min1;
                                retry_reg <= 1'b0;
                                rate_reg  <= '0;
                                known_reg <= 1'b0;
                                ev_reg    <= EV_RESET;
                            end else begin
                                win_reg   <= win_min;
                                retry_reg <= 1'b1;
                                ev_reg    <= EV_RETRY;
                            end
                        end else begin
                            win_reg  <= win_grow;
                            send_reg <= 1'b0;
                            ev_reg   <= EV_GROWN;
                        end
                    end else begin
                        k_reg     <= bpos_reg;
                        acc_reg   <= '0;
                        state_reg <= S_SUM;
                    end
                end
                S_SUM: begin
                    acc_reg <= acc_reg + SUM_W'(st_rd_data);
                    k_reg   <= k_plus;
                    if (k_reg == sum_end) begin
                        state_reg <= S_AVG_GO;
                    end
                end
                S_AVG_GO: begin
                    state_reg <= S_AVG_WAIT;
                end
                S_AVG_WAIT: begin
                    if (div_done) begin
                        avg_reg   <= div_quo[DW-1:0];
                        state_reg <= S_AVG_CHK;
                    end
                end
                S_AVG_CHK: begin
                    avg_out_reg <= avg_reg;
                    if (avg_is_sent) begin
                        count_reg <= '0;
                        win_reg   <= win_min1;
                        retry_reg <= 1'b0;
                        rate_reg  <= '0;
                        known_reg <= 1'b0;
                        send_reg  <= 1'b0;
                        ev_reg    <= EV_RESET;
                        state_reg <= S_OUT;
                    end else if (est == '0) begin
                        count_reg <= '0;
                        win_reg   <= win_min;
                        retry_reg <= 1'b0;
                        rate_reg  <= RATE_TOP;
                        known_reg <= 1'b1;
                        send_reg  <= 1'b1;
                        ev_reg    <= EV_RATE;
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_RATE_WAIT;
                    end
                end
                S_RATE_WAIT: begin
                    if (div_done) begin
                        count_reg <= '0;
                        win_reg   <= win_min;
                        retry_reg <= 1'b0;
                        rate_reg  <= rate_of_quotient(div_quo[15:0]);
                        known_reg <= 1'b1;
                        send_reg  <= 1'b1;
                        ev_reg    <= EV_RATE;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_event_reg <= ev_reg;
                        m_send_reg  <= send_reg;
                        m_rate_reg  <= rate_reg;
                        m_known_reg <= known_reg;
                        m_avg_reg   <= avg_out_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = m_valid_reg;
    assign m_event = m_event_reg;
    assign m_send  = m_send_reg;
    assign m_rate  = m_rate_reg;
    assign m_known = m_known_reg;
    assign m_avg   = m_avg_reg;

endmodule

`default_nettype wire

// ----- hdl/probe_delay_rate_estimator_top.sv -----
// ----------------------------------------------------------------------------
// probe_delay_rate_estimator_top
// sequence: a beat that only stores runs the sorted insert (one store access
//   per cycle); a round-closing beat adds the run search, the run sum and
//   up to two divisions in the shared divider
// throughput: one beat at a time, s_ready high only while idle; the next beat
//   is taken only once the result is loaded into the output register, which
//   waits while an earlier result is stalled by m_ready
// reset: config registers to defaults, store reads all-ones at once
// ----------------------------------------------------------------------------
`default_nettype none

module probe_delay_rate_estimator_top #(
    parameter int MAX_WINDOW = 16,
    parameter int DELAY_BITS = 32
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [pdre_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [31:0]                       cfg_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [31:0]                       s_reported_delay,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [2:0]                             m_event_res,
    output logic                                   m_send_info,
    output logic [2:0]                             m_rate_code,
    output logic                                   m_rate_valid,
    output logic [31:0]                            m_average_delay
);
    import pdre_pkg::*;

    localparam int AW    = $clog2(MAX_WINDOW);
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = DELAY_BITS + CNT_W;

    logic [15:0] packet_size_reg;
    logic [15:0] range_width_reg;
    logic [31:0] sentinel_reg;
    logic [4:0]  min_window_reg;

    st_ctl_t                 st_ctl;
    logic [AW-1:0]           st_wr_addr;
    logic [DELAY_BITS-1:0]   st_wr_data;
    logic [AW-1:0]           st_rd_addr;
    logic [DELAY_BITS-1:0]   st_rd_data;
    logic                    div_start;
    logic [SUM_W-1:0]        div_num;
    logic [DEN_W-1:0]        div_den;
    logic                    div_done;
    logic [SUM_W-1:0]        div_quo;
    event_t                  m_event;
    logic [DELAY_BITS-1:0]   m_avg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            packet_size_reg <= PACKET_SIZE_RST;
            range_width_reg <= RANGE_WIDTH_RST;
            sentinel_reg    <= SENTINEL_RST;
            min_window_reg  <= MIN_WINDOW_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_PACKET_SIZE:    packet_size_reg <= cfg_data[15:0];
                REG_RANGE_WIDTH:    range_width_reg <= cfg_data[15:0];
                REG_SENTINEL_DELAY: sentinel_reg    <= cfg_data;
                REG_MIN_WINDOW:     min_window_reg  <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    pdre_store #(
        .DEPTH (MAX_WINDOW),
        .DW    (DELAY_BITS)
    ) u_store (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (st_ctl),
        .wr_addr     (st_wr_addr),
        .wr_data     (st_wr_data),
        .clear_value (sentinel_reg[DELAY_BITS-1:0]),
        .rd_addr     (st_rd_addr),
        .rd_data     (st_rd_data)
    );

    pdre_div #(
        .NUM_W (SUM_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    pdre_seq #(
        .MAX_WINDOW (MAX_WINDOW),
        .DW         (DELAY_BITS)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_delay     (s_reported_delay[DELAY_BITS-1:0]),
        .packet_size (packet_size_reg),
        .range_width (range_width_reg),
        .sentinel    (sentinel_reg[DELAY_BITS-1:0]),
        .min_window  (min_window_reg),
        .st_ctl      (st_ctl),
        .st_wr_addr  (st_wr_addr),
        .st_wr_data  (st_wr_data),
        .st_rd_addr  (st_rd_addr),
        .st_rd_data  (st_rd_data),
        .div_start   (div_start),
        .div_num     (div_num),
        .div_den     (div_den),
        .div_done    (div_done),
        .div_quo     (div_quo),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_event     (m_event),
        .m_send      (m_send_info),
        .m_rate      (m_rate_code),
        .m_known     (m_rate_valid),
        .m_avg       (m_avg)
    );

    assign m_event_res     = m_event;
    assign m_average_delay = 32'(m_avg);

endmodule

`default_nettype wire

// ----- hdl/pdre_checker.sv -----
// ----------------------------------------------------------------------------
// pdre_checker
// port-level checks on the estimator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module pdre_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [2:0]  m_event_res,
    input wire logic        m_send_info,
    input wire logic [2:0]  m_rate_code,
    input wire logic        m_rate_valid,
    input wire logic [31:0] m_average_delay
);
    import pdre_pkg::*;

    // one beat in flight
    a_one_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a beat is in flight");

    a_rate_known: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_rate_valid |-> m_rate_code == 3'd0)
        else $error("rate code set without a known rate");

    a_stored: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_res == EV_STORED |-> !m_send_info && m_average_delay == 32'd0)
        else $error("stored beat carries info or average");

    a_estimate: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_res == EV_RATE |-> m_send_info && m_rate_valid)
        else $error("rate estimate without info or valid rate");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_res) && $stable(m_average_delay))
        else $error("result beat changed while stalled");

endmodule

bind probe_delay_rate_estimator_top pdre_checker u_pdre_checker (.*);

`default_nettype wire

// ----- bench/tb_probe_delay_rate_estimator_top.sv -----
// ----------------------------------------------------------------------------
// tb_probe_delay_rate_estimator_top
// Self-checking bench for the probe delay rate estimator. Delays go in on a
// valid/ready channel with random gaps. A scoreboard keeps its own sorted
// delay window, run search and rate mapping, and checks every result beat
// field by field. The run starts with short directed sequences: zero average,
// sentinel average, saturated estimate, window growth and zero packet size.
// It then sends bursts of clustered, scattered and raw delays under several
// register settings, including extremes and unmasked register data.
// ----------------------------------------------------------------------------
module tb_probe_delay_rate_estimator_top;
    import pdre_pkg::*;

    localparam int          WINDOW_MAX  = 16;
    localparam int          WINDOW_STEP = 2;
    localparam int          STALL_LIMIT = 2000;
    localparam int          TAIL_CYCLES = 300;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'hA5;
    localparam bit [7:0]    RATE_LIMITS [7] = '{8'd38, 8'd53, 8'd78, 8'd105,
                                                8'd150, 8'd210, 8'd255};

    typedef struct {
        event_t      ev;
        logic        send;
        logic [2:0]  rate;
        logic        known;
        logic [31:0] avg;
    } rate_report_t;

    class rate_scoreboard;
        bit [15:0]    packet_size;
        bit [15:0]    range_width;
        bit [31:0]    sentinel;
        bit [4:0]     min_window;
        bit [31:0]    delays [WINDOW_MAX];
        int unsigned  received;
        int unsigned  window;
        bit           retry;
        bit [2:0]     rate;
        bit           known;
        rate_report_t pending [$];
        int           mismatches;
        int           delays_noted;
        int           results_checked;
        int           ev_tally [5];

        function new();
            packet_size = PACKET_SIZE_RST;
            range_width = RANGE_WIDTH_RST;
            sentinel    = SENTINEL_RST;
            min_window  = MIN_WINDOW_RST;
            full_reset();
        endfunction

        function int unsigned cap_window(int unsigned w);
            return (w > WINDOW_MAX) ? WINDOW_MAX : w;
        endfunction

        function void clear_delays();
            foreach (delays[i]) delays[i] = sentinel;
        endfunction

        function void full_reset();
            clear_delays();
            received = 0;
            window   = cap_window(min_window + 1);
            retry    = 0;
            rate     = 0;
            known    = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, bit [31:0] data);
            case (idx)
                REG_PACKET_SIZE:    packet_size = data[15:0];
                REG_RANGE_WIDTH:    range_width = data[15:0];
                REG_SENTINEL_DELAY: sentinel    = data;
                REG_MIN_WINDOW:     min_window  = data[4:0];
                default: ;
            endcase
        endfunction

        function void insert_sorted(bit [31:0] d);
            int last;
            last = (received > WINDOW_MAX - 1) ? WINDOW_MAX - 1 : received;
            for (int i = 0; i <= last; i++) begin
                if (d < delays[i]) begin
                    for (int j = last; j > i; j--) delays[j] = delays[j - 1];
                    delays[i] = d;
                    return;
                end
            end
        endfunction

        function bit longest_run(output bit [31:0] avg);
            int unsigned w, n, best, best_pos;
            bit [31:0]   spread;
            bit [63:0]   sum;
            w        = cap_window(window);
            best     = 0;
            best_pos = 0;
            sum      = 0;
            avg      = 0;
            for (int i = 0; i < w; i++) begin
                n = 0;
                for (int j = i + 1; j < w; j++) begin
                    spread = delays[j] - delays[i];
                    if (spread <= {16'd0, range_width}) n++;
                    else break;
                end
                if (n > best) begin
                    best     = n;
                    best_pos = i;
                end
            end
            if (best < 2) return 0;
            for (int j = best_pos; j <= best_pos + best && j < WINDOW_MAX; j++)
                sum += delays[j];
            avg = 32'(sum / (best + 1));
            return 1;
        endfunction

        function bit [2:0] rate_for_average(bit [31:0] avg);
            bit [15:0] est, q;
            est = (avg > 32'd65535) ? 16'hFFFF : avg[15:0];
            if (est == 0) return 3'd7;
            q = packet_size / est;
            for (int k = 0; k < 7; k++)
                if (q < {8'd0, RATE_LIMITS[k]}) return 3'(k);
            return 3'd7;
        endfunction

        function void note_delay(bit [31:0] d);
            rate_report_t want;
            bit [31:0]    avg;
            want.ev   = EV_STORED;
            want.send = 0;
            want.avg  = 0;
            insert_sorted(d);
            if (received < WINDOW_MAX) received++;
            if (received >= window) begin
                if (!longest_run(avg)) begin
                    if (cap_window(window) >= WINDOW_MAX) begin
                        if (retry) begin
                            full_reset();
                            want.ev = EV_RESET;
                        end else begin
                            clear_delays();
                            received = 0;
                            window   = cap_window(min_window);
                            retry    = 1;
                            want.ev  = EV_RETRY;
                        end
                        want.send = 1;
                    end else begin
                        window  = cap_window(window + WINDOW_STEP);
                        want.ev = EV_GROWN;
                    end
                end else if (avg == sentinel) begin
                    full_reset();
                    want.avg = avg;
                    want.ev  = EV_RESET;
                end else begin
                    clear_delays();
                    received  = 0;
                    window    = cap_window(min_window);
                    retry     = 0;
                    rate      = rate_for_average(avg);
                    known     = 1;
                    want.avg  = avg;
                    want.send = 1;
                    want.ev   = EV_RATE;
                end
            end
            want.rate  = rate;
            want.known = known;
            ev_tally[want.ev]++;
            pending.push_back(want);
            delays_noted++;
        endfunction

        function void report(string field, logic [31:0] want, logic [31:0] seen);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s, result %0d: expected %0h, got %0h",
                         field, results_checked, want, seen);
        endfunction

        function void check_result(rate_report_t seen);
            rate_report_t want;
            results_checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d arrived with no delay waiting", results_checked);
                return;
            end
            want = pending.pop_front();
            if (seen.ev !== want.ev)       report("event_res", want.ev, seen.ev);
            if (seen.send !== want.send)   report("send_info", want.send, seen.send);
            if (seen.rate !== want.rate)   report("rate_code", want.rate, seen.rate);
            if (seen.known !== want.known) report("rate_valid", want.known, seen.known);
            if (seen.avg !== want.avg)     report("average_delay", want.avg, seen.avg);
        endfunction

        function int outstanding();
            return pending.size();
        endfunction
    endclass

    logic                 aclk             = 1'b0;
    logic                 aresetn          = 1'b0;
    logic                 cfg_valid        = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index        = '0;
    logic [31:0]          cfg_data         = '0;
    logic                 s_valid          = 1'b0;
    logic                 s_ready;
    logic [31:0]          s_reported_delay = '0;
    logic                 m_valid;
    logic                 m_ready          = 1'b0;
    logic [2:0]           m_event_res;
    logic                 m_send_info;
    logic [2:0]           m_rate_code;
    logic                 m_rate_valid;
    logic [31:0]          m_average_delay;

    bit             no_gaps;
    int             settings_applied;
    rate_scoreboard sb = new();

    probe_delay_rate_estimator_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_reported_delay(s_reported_delay),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_res     (m_event_res),
        .m_send_info     (m_send_info),
        .m_rate_code     (m_rate_code),
        .m_rate_valid    (m_rate_valid),
        .m_average_delay (m_average_delay)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input bit [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_register(idx, data);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apply_settings(input bit [31:0] pkt, input bit [31:0] rng,
                                  input bit [31:0] sent, input bit [31:0] minw);
        write_reg(REG_PACKET_SIZE, pkt);
        write_reg(REG_RANGE_WIDTH, rng);
        write_reg(REG_SENTINEL_DELAY, sent);
        write_reg(REG_MIN_WINDOW, minw);
        settings_applied++;
    endtask

    task automatic send_delay(input bit [31:0] d);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_reported_delay <= d;
        do @(posedge aclk); while (!s_ready);
        sb.note_delay(d);
    endtask

    // lower valid and hold off until every result is back
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.outstanding() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    // bursts: tight clusters within the range width, scattered delays, raw values
    task automatic random_delays(input int count);
        int        sent, len, kind, pick;
        bit [31:0] base, d, rng;
        sent = 0;
        while (sent < count) begin
            rng  = sb.range_width;
            len  = $urandom_range(1, 16);
            kind = $urandom_range(0, 99);
            pick = $urandom_range(0, 9);
            if (pick < 5)      base = $urandom_range(0, 120);
            else if (pick < 8) base = $urandom_range(0, 70000);
            else               base = $urandom();
            for (int k = 0; k < len && sent < count; k++) begin
                if (kind < 60) begin
                    d = base + $urandom_range(0, rng);
                end else if (kind < 85) begin
                    d = base + $urandom_range(0, rng * 20 + 5000);
                end else begin
                    pick = $urandom_range(0, 9);
                    if (pick == 0)      d = 32'd0;
                    else if (pick == 1) d = 32'hFFFF_FFFF;
                    else if (pick == 2) d = sb.sentinel;
                    else                d = $urandom();
                end
                send_delay(d);
                sent++;
            end
        end
    endtask

    initial begin : result_sink
        int           gap;
        rate_report_t seen;
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = no_gaps ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            seen.ev    = event_t'(m_event_res);
            seen.send  = m_send_info;
            seen.rate  = m_rate_code;
            seen.known = m_rate_valid;
            seen.avg   = m_average_delay;
            sb.check_result(seen);
        end
    end

    initial begin : watchdog
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                stalled = 0;
            else
                stalled++;
        end
        $display("no beat moved for %0d cycles", STALL_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        bit [31:0] sent_hi;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero average, sentinel average, saturated estimate, window growth
        repeat (5) send_delay(32'd0);
        repeat (4) send_delay(32'hFFFF_FFFF);
        repeat (5) send_delay(32'd100000);
        for (int k = 0; k < 6; k++) send_delay(32'd10000 + 32'd1000 * k);
        drain_results();

        // zero packet size with an exact-match run
        apply_settings(32'd0, 32'd0, 32'hFFFF_FFFF, 32'd16);
        repeat (4) send_delay(32'd20);
        drain_results();

        apply_settings(32'd1500, 32'd50, 32'hFFFF_FFFF, 32'd4);
        random_delays(150);
        drain_results();
        random_delays(150);
        drain_results();

        sent_hi     = $urandom();
        sent_hi[31] = 1'b1;
        apply_settings(32'd65535, 32'd65535, sent_hi, 32'd16);
        random_delays(300);
        drain_results();

        no_gaps = 1'b1;
        apply_settings(32'd1, 32'd0, 32'hFFFF_FFFF, 32'd2);
        random_delays(300);
        drain_results();
        no_gaps = 1'b0;

        apply_settings($urandom_range(1, 65535), $urandom_range(0, 2000), 32'hFFFF_FFFF,
                       $urandom_range(2, 16));
        random_delays(300);
        drain_results();

        // unmasked register data and a write to an unmapped index
        write_reg(REG_UNUSED, $urandom());
        apply_settings($urandom(), $urandom(), $urandom(), $urandom());
        random_delays(300);
        drain_results();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.outstanding() != 0)
            $display("%0d expected results never arrived", sb.outstanding());
        $display("%0d delays, %0d results under %0d register settings, %0d mismatches",
                 sb.delays_noted, sb.results_checked, settings_applied, sb.mismatches);
        $display("events: stored %0d, grown %0d, retry %0d, reset %0d, estimated %0d",
                 sb.ev_tally[EV_STORED], sb.ev_tally[EV_GROWN], sb.ev_tally[EV_RETRY],
                 sb.ev_tally[EV_RESET], sb.ev_tally[EV_RATE]);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
